// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check under a clock, with the check held off while reset is low.
`define TRHD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check under a clock at every edge, reset included.
`define TRHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRHD_ASSERT(lbl, clk, rst_n, prop, msg)
`define TRHD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/trhd_pkg.sv =====
`timescale 1ns / 1ps
package trhd_pkg;

	// Default table depth and coordinate width
	localparam int MaxRegions = 64;
	localparam int CoordBits  = 12;

	// Width of the region index in a result
	localparam int IndexBits = 6;

	// Request operation codes
	localparam logic OP_POLL = 1'b0;
	localparam logic OP_ADD  = 1'b1;

	// One result
	typedef struct packed {
		logic                 hit_valid;
		logic [IndexBits-1:0] region_index;
		logic                 table_full;
		logic                 last;
	} rsp_t;

endpackage

// ===== hw/rtl/trhd_req_if.sv =====
`timescale 1ns / 1ps
interface trhd_req_if #(
	parameter int COORD_BITS = trhd_pkg::CoordBits
);
	logic                  valid;
	logic                  ready;
	logic                  operation;
	logic                  touch_present;
	logic [COORD_BITS-1:0] touch_x;
	logic [COORD_BITS-1:0] touch_y;
	logic [COORD_BITS-1:0] region_left;
	logic [COORD_BITS-1:0] region_right;
	logic [COORD_BITS-1:0] region_top;
	logic [COORD_BITS-1:0] region_bottom;

	modport source (
		output valid, operation, touch_present, touch_x, touch_y,
		       region_left, region_right, region_top, region_bottom,
		input  ready
	);

	modport sink (
		input  valid, operation, touch_present, touch_x, touch_y,
		       region_left, region_right, region_top, region_bottom,
		output ready
	);
endinterface

// ===== hw/rtl/trhd_rsp_if.sv =====
`timescale 1ns / 1ps
interface trhd_rsp_if;
	import trhd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 hit_valid;
	logic [IndexBits-1:0] region_index;
	logic                 table_full;
	logic                 last;

	modport source (
		output valid, hit_valid, region_index, table_full, last,
		input  ready
	);

	modport sink (
		input  valid, hit_valid, region_index, table_full, last,
		output ready
	);
endinterface

// ===== hw/rtl/touch_region_hit_detector.sv =====
`timescale 1ns / 1ps
// Touch region hit detector.
// The req channel carries two kinds of request. An add request (operation
// high) appends one rectangle, inclusive bounds, to a table of MAX_REGIONS
// entries; a poll request carries touch_present and a coordinate pair.
// The rsp channel returns results; the final result of each request has
// last set. An add, or any poll that is not a new press, returns one result
// (table_full set when an add found the table full). A new press walks the
// table and returns one result per hit region, in ascending index order, or
// one empty result when nothing is hit.
// Timing: the result of an add or plain poll is in the output register on the
// next cycle after it is taken. For a new press the table memory has one
// read port and the scan reads one entry per cycle while not stalled,
// comparing it against the latched coordinate on the next. req.ready is
// high only between requests.
// A stalled rsp holds the output register; the scan stops at the next hit
// that needs the register and resumes when the result is taken.
// Reset clears the region count, the pressed flag and the output valid flag;
// table contents are not cleared and need no clearing pass.
module touch_region_hit_detector #(
	parameter int MAX_REGIONS = trhd_pkg::MaxRegions,
	parameter int COORD_BITS  = trhd_pkg::CoordBits
) (
	input  logic       clk,
	input  logic       arst_n,
	trhd_req_if.sink   req,
	trhd_rsp_if.source rsp
);
	import trhd_pkg::*;

	`include "assert_macros.svh"

	localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	typedef struct packed {
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] right;
		logic [COORD_BITS-1:0] top;
		logic [COORD_BITS-1:0] bottom;
	} region_t;

	region_t mem [MAX_REGIONS];
	region_t rd_q;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  press_q;
	logic [COORD_BITS-1:0] tx_q;
	logic [COORD_BITS-1:0] ty_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic [IDX_W-1:0]      tst_idx_q;
	logic                  tst_valid_q;
	logic [IDX_W-1:0]      pend_idx_q;
	logic                  pend_valid_q;
	rsp_t                  out_q;
	logic                  out_valid_q;

	logic out_free;
	logic accept;
	logic full;
	logic mem_we;
	logic more;
	logic hit;
	logic stall;
	logic rd_en;
	logic new_press;
	logic out_load;

	// Handshake and scan control
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign accept = req.valid && req.ready;
	assign full = (cnt_q == CNT_W'(MAX_REGIONS));
	assign mem_we = accept && (req.operation == OP_ADD) && !full;
	assign more = (rd_idx_q < cnt_q);
	assign new_press = accept && (req.operation == OP_POLL) && !press_q
		&& req.touch_present;

	// Inclusive bounds test of the entry held in the read register
	assign hit = tst_valid_q
		&& (rd_q.left <= tx_q) && (tx_q <= rd_q.right)
		&& (rd_q.top <= ty_q) && (ty_q <= rd_q.bottom);
	assign stall = hit && pend_valid_q && !out_free;
	assign rd_en = (state_q == ST_SCAN) && !stall && more;

	// Load the output register on a plain request, a pushed-out hit or the close
	assign out_load = (accept && !new_press)
		|| ((state_q == ST_SCAN) && !stall && hit && pend_valid_q)
		|| ((state_q == ST_DONE) && out_free);

	// Region table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_q[IDX_W-1:0]] <= '{left: req.region_left, right: req.region_right,
				top: req.region_top, bottom: req.region_bottom};
		end
		if (rd_en) begin
			rd_q <= mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	// Sequencer, table count, pressed flag and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			press_q      <= 1'b0;
			rd_idx_q     <= '0;
			tst_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !rsp.ready);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						out_q <= '{hit_valid: 1'b0, region_index: '0,
							table_full: (req.operation == OP_ADD) && full, last: 1'b1};
						if (req.operation == OP_ADD) begin
							if (!full) begin
								cnt_q <= cnt_q + 1'b1;
							end
						end else if (press_q) begin
							if (!req.touch_present) begin
								press_q <= 1'b0;
							end
						end else if (req.touch_present) begin
							// New press: start the walk
							press_q      <= 1'b1;
							tx_q         <= req.touch_x;
							ty_q         <= req.touch_y;
							rd_idx_q     <= '0;
							tst_valid_q  <= 1'b0;
							pend_valid_q <= 1'b0;
							state_q      <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (!stall) begin
						// Keep the newest hit; push the one before it out
						if (hit) begin
							pend_idx_q   <= tst_idx_q;
							pend_valid_q <= 1'b1;
							if (pend_valid_q) begin
								out_q <= '{hit_valid: 1'b1,
									region_index: IndexBits'(pend_idx_q),
									table_full: 1'b0, last: 1'b0};
							end
						end
						// Advance the read address
						if (more) begin
							tst_idx_q   <= rd_idx_q[IDX_W-1:0];
							tst_valid_q <= 1'b1;
							rd_idx_q    <= rd_idx_q + 1'b1;
						end else begin
							tst_valid_q <= 1'b0;
							if (!tst_valid_q) begin
								state_q <= ST_DONE;
							end
						end
					end
				end
				ST_DONE: begin
					// Close the press with the held hit, or an empty result
					if (out_free) begin
						out_q        <= '{hit_valid: pend_valid_q,
							region_index: pend_valid_q ? IndexBits'(pend_idx_q) : '0,
							table_full: 1'b0, last: 1'b1};
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Drive the result channel
	assign rsp.valid        = out_valid_q;
	assign rsp.hit_valid    = out_q.hit_valid;
	assign rsp.region_index = out_q.region_index;
	assign rsp.table_full   = out_q.table_full;
	assign rsp.last         = out_q.last;

	`TRHD_ASSERT_ALWAYS(a_cnt_bound, clk, cnt_q <= CNT_W'(MAX_REGIONS), "region count past table depth")
	`TRHD_ASSERT(a_tst_in_table, clk, arst_n, tst_valid_q |-> (CNT_W'(tst_idx_q) < cnt_q), "scan read past stored regions")
	`TRHD_ASSERT(a_pend_in_table, clk, arst_n, pend_valid_q |-> (CNT_W'(pend_idx_q) < cnt_q), "held hit past stored regions")
	`TRHD_ASSERT(a_nonlast_is_hit, clk, arst_n, (rsp.valid && !rsp.last) |-> (rsp.hit_valid && !rsp.table_full), "non-final result without hit")

endmodule
